// File: hdl/identifier_slug_normalizer_macros.svh
// Assertion macros shared by the slug normalizer RTL
`ifndef IDENTIFIER_SLUG_NORMALIZER_MACROS_SVH
`define IDENTIFIER_SLUG_NORMALIZER_MACROS_SVH
`ifndef ASSERT_OFF
`define ISN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define ISN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ISN_ASSERT_IMP(lbl, ante, cons, msg)
`define ISN_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// File: hdl/isn_pkg.sv
// Types and constants of the identifier slug normalizer
package isn_pkg;

  localparam int unsigned CpW   = 21;
  localparam int unsigned CharW = 7;

  localparam logic [CharW-1:0] CharUnderscore = 7'h5F;
  localparam logic [CharW-1:0] CharNone       = 7'h00;
  localparam logic [CharW-1:0] CharDigit0     = 7'h30;
  localparam logic [CharW-1:0] CharDigit9     = 7'h39;
  localparam logic [CharW-1:0] CharA          = 7'h61;
  localparam logic [CharW-1:0] CharC          = 7'h63;
  localparam logic [CharW-1:0] CharD          = 7'h64;
  localparam logic [CharW-1:0] CharE          = 7'h65;
  localparam logic [CharW-1:0] CharI          = 7'h69;
  localparam logic [CharW-1:0] CharN          = 7'h6E;
  localparam logic [CharW-1:0] CharO          = 7'h6F;
  localparam logic [CharW-1:0] CharS          = 7'h73;
  localparam logic [CharW-1:0] CharT          = 7'h74;
  localparam logic [CharW-1:0] CharU          = 7'h75;
  localparam logic [CharW-1:0] CharY          = 7'h79;

  localparam logic [7:0] Latin1Lo    = 8'hC0;
  localparam logic [7:0] Latin1Mul   = 8'hD7;
  localparam logic [7:0] Latin1Div   = 8'hF7;
  localparam logic [7:0] Latin1Thorn = 8'hFE;
  localparam logic [7:0] Latin1YDia  = 8'hFF;

  // one result transaction
  typedef struct packed {
    logic [CharW-1:0] out_char;
    logic             char_valid;
    logic             end_of_name;
    logic             end_of_run;
  } isn_item_t;

  // results pushed into the output buffer in one cycle, first goes out first
  typedef struct packed {
    logic [1:0] count;
    isn_item_t  first;
    isn_item_t  second;
  } isn_push_t;

endpackage

// File: hdl/identifier_slug_normalizer.sv
// Top level of the identifier slug normalizer
// Flow: an accepted input transaction is held in the input register, folded from it, and
//   its results are written into the output queue, from which the first can then be taken.
// Throughput: one input transaction per cycle while the output queue has room for its results;
//   an input that yields an inserted underscore plus a character sends them out one at a time.
// Reset: rst_ni clears the input valid, queue count and slug state; payload is not reset.
module identifier_slug_normalizer (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [isn_pkg::CpW-1:0]   code_point_i,
  input  logic                      last_in_name_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [isn_pkg::CharW-1:0] out_char_o,
  output logic                      char_valid_o,
  output logic                      end_of_name_o,
  output logic                      end_of_run_o
);
  import isn_pkg::*;

  `include "identifier_slug_normalizer_macros.svh"

  // input register
  logic                 in_valid_q;
  logic [CpW-1:0]       cp_q;
  logic                 last_q;
  logic                 load;
  logic                 advance;

  // slug state
  logic                 emitted_any_q, emitted_any_d;
  logic                 sep_pending_q, sep_pending_d;
  logic                 prior_digit_q, prior_digit_d;

  logic [CharW-1:0]     fold_char;
  logic                 is_char;
  logic                 is_digit;
  logic                 need_us;
  isn_push_t            push;
  isn_push_t            gen;
  logic [1:0]           free;
  isn_item_t            head;

  isn_fold u_fold (
    .code_point_i (cp_q),
    .fold_char_o  (fold_char)
  );

  assign is_char  = (fold_char != CharNone);
  assign is_digit = (fold_char >= CharDigit0) && (fold_char <= CharDigit9);
  // underscore goes in for a pending separator run or a letter/digit change
  assign need_us  = emitted_any_q && (sep_pending_q || (is_digit != prior_digit_q));

  // results this transaction would produce
  always_comb begin
    gen.count  = 2'd0;
    gen.first  = '{out_char: CharNone, char_valid: 1'b0, end_of_name: 1'b0, end_of_run: 1'b0};
    gen.second = gen.first;
    if (is_char) begin
      if (need_us) begin
        gen.count  = 2'd2;
        gen.first  = '{out_char: CharUnderscore, char_valid: 1'b1,
                       end_of_name: 1'b0, end_of_run: 1'b0};
        gen.second = '{out_char: fold_char, char_valid: 1'b1,
                       end_of_name: last_q, end_of_run: 1'b1};
      end else begin
        gen.count = 2'd1;
        gen.first = '{out_char: fold_char, char_valid: 1'b1,
                      end_of_name: last_q, end_of_run: 1'b1};
      end
    end else if (last_q) begin
      // bare terminator: name ended on a separator or was empty
      gen.count = 2'd1;
      gen.first = '{out_char: CharNone, char_valid: 1'b0,
                    end_of_name: 1'b1, end_of_run: 1'b1};
    end
  end

  // move on only when the queue has room for every result of this transaction
  assign advance    = in_valid_q && (gen.count <= free);
  assign in_stall_o = in_valid_q && !advance;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    push       = gen;
    push.count = advance ? gen.count : 2'd0;
  end

  always_comb begin
    emitted_any_d = emitted_any_q;
    sep_pending_d = sep_pending_q;
    prior_digit_d = prior_digit_q;
    if (advance) begin
      if (is_char) begin
        emitted_any_d = 1'b1;
        sep_pending_d = 1'b0;
        prior_digit_d = is_digit;
      end else if (emitted_any_q) begin
        sep_pending_d = 1'b1;
      end
      if (last_q) begin
        emitted_any_d = 1'b0;
        sep_pending_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q    <= 1'b0;
      emitted_any_q <= 1'b0;
      sep_pending_q <= 1'b0;
      prior_digit_q <= 1'b0;
    end else begin
      in_valid_q    <= load || (in_valid_q && !advance);
      emitted_any_q <= emitted_any_d;
      sep_pending_q <= sep_pending_d;
      prior_digit_q <= prior_digit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cp_q   <= code_point_i;
      last_q <= last_in_name_i;
    end
  end

  isn_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .free_o      (free),
    .item_o      (head),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

  assign out_char_o    = head.out_char;
  assign char_valid_o  = head.char_valid;
  assign end_of_name_o = head.end_of_name;
  assign end_of_run_o  = head.end_of_run;

  // a pending separator only exists after something was emitted
  `ISN_ASSERT_IMP(a_sep_needs_emit, sep_pending_q, emitted_any_q, "separator pending on empty slug")
  // a finished name leaves no slug state behind
  `ISN_ASSERT_NXT(a_name_clears, advance && last_q, !emitted_any_q && !sep_pending_q, "state kept after name end")
  // only the inserted underscore is a non-final result of a transaction
  `ISN_ASSERT_IMP(a_mid_is_us, out_valid_o && !end_of_run_o, char_valid_o && (out_char_o == CharUnderscore) && !end_of_name_o, "bad first result")
  // terminator carries no character and closes the name
  `ISN_ASSERT_IMP(a_bare_term, out_valid_o && !char_valid_o, (out_char_o == CharNone) && end_of_name_o && end_of_run_o, "bad terminator")
  // stall only when a held transaction cannot move
  `ISN_ASSERT_IMP(a_stall_reason, in_stall_o, in_valid_q && (free < gen.count), "spurious input stall")

endmodule

// File: hdl/isn_fold.sv
// Code point folding: Latin-1 and ASCII letters to lower-case ASCII, digits kept, else separator
module isn_fold (
  input  logic [isn_pkg::CpW-1:0]   code_point_i,
  output logic [isn_pkg::CharW-1:0] fold_char_o
);
  import isn_pkg::*;

  logic       in_byte;
  logic [7:0] cp_low;
  logic [4:0] lat_idx;

  assign in_byte = (code_point_i[CpW-1:8] == '0);
  assign cp_low  = code_point_i[7:0];
  // upper and lower Latin-1 letter blocks share one index
  assign lat_idx = cp_low[4:0];

  always_comb begin
    fold_char_o = CharNone;
    if (in_byte) begin
      if (cp_low >= 8'h41 && cp_low <= 8'h5A) begin
        fold_char_o = cp_low[CharW-1:0] | 7'h20;
      end else if ((cp_low >= 8'h61 && cp_low <= 8'h7A) ||
                   (cp_low >= 8'h30 && cp_low <= 8'h39)) begin
        fold_char_o = cp_low[CharW-1:0];
      end else if (cp_low >= Latin1Lo) begin
        case (lat_idx)
          5'h00, 5'h01, 5'h02, 5'h03, 5'h04, 5'h05, 5'h06: fold_char_o = CharA;
          5'h07:                                           fold_char_o = CharC;
          5'h08, 5'h09, 5'h0A, 5'h0B:                      fold_char_o = CharE;
          5'h0C, 5'h0D, 5'h0E, 5'h0F:                      fold_char_o = CharI;
          5'h10:                                           fold_char_o = CharD;
          5'h11:                                           fold_char_o = CharN;
          5'h12, 5'h13, 5'h14, 5'h15, 5'h16, 5'h18:        fold_char_o = CharO;
          5'h19, 5'h1A, 5'h1B, 5'h1C:                      fold_char_o = CharU;
          5'h1D:                                           fold_char_o = CharY;
          5'h1E:                                           fold_char_o = CharT;
          5'h1F:                                           fold_char_o = CharS;
          default:                                         fold_char_o = CharNone;
        endcase
        // y diaeresis and lower thorn break the block symmetry; multiplication and division signs fold to none
        if (cp_low == Latin1YDia) begin
          fold_char_o = CharY;
        end
        if (cp_low == Latin1Thorn || cp_low == Latin1Div || cp_low == Latin1Mul) begin
          fold_char_o = CharNone;
        end
      end
    end
  end

endmodule

// File: hdl/isn_outbuf.sv
// Two-entry output queue for result transactions
module isn_outbuf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  isn_pkg::isn_push_t push_i,
  output logic [1:0]         free_o,
  output isn_pkg::isn_item_t item_o,
  output logic               out_valid_o,
  input  logic               out_stall_i
);
  import isn_pkg::*;

  isn_item_t  slot_q [2];
  isn_item_t  slot_d [2];
  logic [1:0] count_q, count_d;
  logic [1:0] kept;
  logic       pop;

  assign out_valid_o = (count_q != 2'd0);
  assign item_o      = slot_q[0];
  assign pop         = out_valid_o && !out_stall_i;
  assign kept        = count_q - {1'b0, pop};
  assign free_o      = 2'd2 - kept;

  always_comb begin
    slot_d[0] = slot_q[0];
    slot_d[1] = slot_q[1];
    case (kept)
      2'd0: begin
        slot_d[0] = push_i.first;
        slot_d[1] = push_i.second;
      end
      2'd1: begin
        slot_d[0] = pop ? slot_q[1] : slot_q[0];
        slot_d[1] = push_i.first;
      end
      default: begin
        slot_d[0] = slot_q[0];
        slot_d[1] = slot_q[1];
      end
    endcase
    count_d = kept + push_i.count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q[0] <= slot_d[0];
    slot_q[1] <= slot_d[1];
  end

endmodule

// File: bench/tb_top.sv
// Testbench for identifier_slug_normalizer: random names checked against a slug predictor
`timescale 1ns / 100ps

import isn_pkg::*;

// Predicts the slug characters of every accepted code point and checks the results in order
class slug_scoreboard;
  isn_item_t   expected_slug_q[$];
  bit          emitted_any;
  bit          sep_pending;
  bit          prior_digit;
  int unsigned mismatch_count;

  // Fold a code point to a lower-case letter or digit; CharNone marks a separator
  function logic [CharW-1:0] fold_code_point(logic [CpW-1:0] cp);
    logic [7:0] lo;
    if (cp >= "A" && cp <= "Z") return cp[CharW-1:0] + 7'h20;
    if ((cp >= "a" && cp <= "z") || (cp >= "0" && cp <= "9")) return cp[CharW-1:0];
    if (cp < Latin1Lo || cp > Latin1YDia) return CharNone;
    if (cp[7:0] == Latin1YDia) return CharY;
    if (cp[7:0] == Latin1Thorn || cp[7:0] == Latin1Div) return CharNone;
    // lower-case block folds onto the upper-case one
    lo = {cp[7:6], 1'b0, cp[4:0]};
    if (lo <= 8'hC6) return CharA;    // includes the AE ligature
    if (lo == 8'hC7) return CharC;
    if (lo <= 8'hCB) return CharE;
    if (lo <= 8'hCF) return CharI;
    if (lo == 8'hD0) return CharD;
    if (lo == 8'hD1) return CharN;
    if (lo <= 8'hD6) return CharO;
    if (lo == Latin1Mul) return CharNone;
    if (lo == 8'hD8) return CharO;
    if (lo <= 8'hDC) return CharU;
    if (lo == 8'hDD) return CharY;
    if (lo == 8'hDE) return CharT;
    return CharS;
  endfunction

  function void note_code_point(logic [CpW-1:0] cp, logic last);
    logic [CharW-1:0] ch;
    bit               is_digit;
    ch = fold_code_point(cp);
    if (ch != CharNone) begin
      is_digit = (ch >= CharDigit0 && ch <= CharDigit9);
      if (emitted_any && (sep_pending || is_digit != prior_digit))
        expected_slug_q.push_back(isn_item_t'{CharUnderscore, 1'b1, 1'b0, 1'b0});
      sep_pending = 1'b0;
      expected_slug_q.push_back(isn_item_t'{ch, 1'b1, last, 1'b1});
      emitted_any = 1'b1;
      prior_digit = is_digit;
    end else begin
      if (emitted_any) sep_pending = 1'b1;
      // name ended on a separator: bare terminator
      if (last) expected_slug_q.push_back(isn_item_t'{CharNone, 1'b0, 1'b1, 1'b1});
    end
    if (last) begin
      emitted_any = 1'b0;
      sep_pending = 1'b0;
    end
  endfunction

  task report_mismatch(string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  task check_slug_item(isn_item_t got);
    isn_item_t exp;
    if (expected_slug_q.size() == 0) begin
      report_mismatch($sformatf("unexpected transaction char=%h", got.out_char));
      return;
    end
    exp = expected_slug_q.pop_front();
    if (got.out_char !== exp.out_char)
      report_mismatch($sformatf("out_char %h, want %h", got.out_char, exp.out_char));
    if (got.char_valid !== exp.char_valid)
      report_mismatch($sformatf("char_valid %b, want %b", got.char_valid, exp.char_valid));
    if (got.end_of_name !== exp.end_of_name)
      report_mismatch($sformatf("end_of_name %b, want %b", got.end_of_name, exp.end_of_name));
    if (got.end_of_run !== exp.end_of_run)
      report_mismatch($sformatf("end_of_run %b, want %b", got.end_of_run, exp.end_of_run));
  endtask
endclass

module tb_top;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomItems = 800;
  localparam int unsigned HoldCycles  = 300;

  typedef enum int unsigned {StallNone, StallLight, StallHeavy, StallHold} stall_mode_e;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic [CpW-1:0]     code_point_i   = '0;
  logic               last_in_name_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic [CharW-1:0]   out_char_o;
  logic               char_valid_o;
  logic               end_of_name_o;
  logic               end_of_run_o;

  slug_scoreboard sb = new();
  int unsigned    cycle_count;
  int unsigned    items_sent;
  int unsigned    burst_left;

  identifier_slug_normalizer uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .code_point_i   (code_point_i),
    .last_in_name_i (last_in_name_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_char_o     (out_char_o),
    .char_valid_o   (char_valid_o),
    .end_of_name_o  (end_of_name_o),
    .end_of_run_o   (end_of_run_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Both handshakes are sampled at the rising edge; inputs only move on the falling edge.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      sb.note_code_point(code_point_i, last_in_name_i);
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_slug_item(isn_item_t'{out_char_o, char_valid_o, end_of_name_o, end_of_run_o});
  end

  // Offer one code point; the sender runs in bursts with random idle gaps in between.
  // Returns once the transaction is accepted, just after the rising edge.
  task automatic offer_code_point(input logic [CpW-1:0] cp, input logic last);
    int unsigned idle;
    @(negedge clk_i);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (idle != 0) begin
        in_valid_i   <= 1'b0;
        code_point_i <= CpW'($urandom_range(0, 21'h1FFFFF));   // junk while idle
        repeat (idle) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    code_point_i   <= cp;
    last_in_name_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  // Weighted mix: letters and digits dominate so that slugs get long and
  // letter/digit changes are frequent; the rest covers Latin-1 and separators.
  function automatic logic [CpW-1:0] pick_code_point();
    case ($urandom_range(0, 9))
      0, 1:    return CpW'("A" + $urandom_range(0, 25));
      2, 3:    return CpW'("a" + $urandom_range(0, 25));
      4, 5:    return CpW'("0" + $urandom_range(0, 9));
      6:       return CpW'(Latin1Lo + $urandom_range(0, 63));
      7:       return CpW'($urandom_range(0, 127));            // any ASCII
      8:       return CpW'($urandom_range(0, 255));
      default: return CpW'($urandom_range(0, 21'h1FFFFF));     // full range, beyond U+10FFFF too
    endcase
  endfunction

  task automatic send_random_name();
    int unsigned len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 10);
    for (int unsigned k = 1; k <= len; k++)
      offer_code_point(pick_code_point(), k == len);
  endtask

  // Receiver stall pattern: stretches of no stall, light or heavy random stall, and
  // long hold-offs. The fourth stretch is always a hold-off so that the block backs up
  // while the sender keeps offering.
  initial begin
    int unsigned round;
    int unsigned span;
    stall_mode_e mode;
    round = 0;
    wait (rst_ni);
    forever begin
      round++;
      if (round == 4 || $urandom_range(0, 15) == 0) begin
        mode = StallHold;
        span = HoldCycles;
      end else begin
        mode = stall_mode_e'($urandom_range(StallNone, StallHeavy));
        span = $urandom_range(20, 200);
      end
      repeat (span) begin
        @(negedge clk_i);
        case (mode)
          StallNone:  out_stall_i <= 1'b0;
          StallLight: out_stall_i <= ($urandom_range(0, 3) == 0);
          StallHeavy: out_stall_i <= ($urandom_range(0, 3) != 0);
          default:    out_stall_i <= 1'b1;
        endcase
      end
    end
  end

  // Directed names: field extremes, separator runs, the AE ligature, Latin-1
  // fold table edges, bare terminators and letter/digit changes. {last, code point}.
  logic [CpW:0] directed_seq [25] = '{
    {1'b0, 21'h000000}, {1'b0, 21'h000041}, {1'b0, 21'h00005A}, {1'b0, 21'h000039},
    {1'b0, 21'h1FFFFF}, {1'b0, 21'h00007A}, {1'b0, 21'h0000C6}, {1'b1, 21'h110000},
    {1'b0, 21'h0000E6}, {1'b0, 21'h00002D}, {1'b0, 21'h00002D}, {1'b0, 21'h0000FF},
    {1'b1, 21'h000030},
    {1'b1, 21'h0000D7},
    {1'b0, 21'h0000C0}, {1'b0, 21'h0000DE}, {1'b0, 21'h0000DF}, {1'b0, 21'h0000FE},
    {1'b0, 21'h0000F7}, {1'b0, 21'h0000D0}, {1'b0, 21'h0000D1}, {1'b0, 21'h0000D8},
    {1'b0, 21'h0000DD}, {1'b0, 21'h10FFFF}, {1'b1, 21'h000061}
  };

  initial begin
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_seq[i])
      offer_code_point(directed_seq[i][CpW-1:0], directed_seq[i][CpW]);

    items_sent = 0;
    while (items_sent < RandomItems)
      send_random_name();

    @(negedge clk_i);
    in_valid_i <= 1'b0;

    // drain, then give the output queue time to show anything stray
    while (sb.expected_slug_q.size() != 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (sb.mismatch_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: files.f
+incdir+hdl
hdl/isn_pkg.sv
hdl/isn_fold.sv
hdl/isn_outbuf.sv
hdl/identifier_slug_normalizer.sv
bench/tb_top.sv
